// ----- hdl/disk_seek_distance_unit_defines.svh -----
// assertion macros for the disk seek distance unit
`ifndef DISK_SEEK_DISTANCE_UNIT_DEFINES_SVH
`define DISK_SEEK_DISTANCE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dsd_pkg.sv -----
// package for the disk seek distance unit: register indexes and reset values
`default_nettype none

package dsd_pkg;

  typedef enum logic [0:0] {
    CfgMaxSector     = 1'b0,
    CfgStartPosition = 1'b1
  } cfg_idx_e;

  localparam int unsigned MaxSectorReset = 199;

endpackage

`default_nettype wire

// ----- hdl/disk_seek_distance_unit.sv -----
// disk seek distance unit: running request statistics and fcfs, scan and c-scan totals
//
// usage: request positions arrive on the s_axis channel, one item per cycle
// while s_axis_tready is high; tdata carries request_position and tlast marks
// the final request of a batch. each accepted item updates running statistics
// (saturating fcfs sum, lowest, highest, nearest below and above start,
// circular low mark). the final item of a batch loads a finish register; from
// there the fcfs, scan and c-scan totals are formed into the output register
// once that is empty or being taken, and the result is then valid on m_axis.
// new items are taken while a result is pending; a result leaves per cycle while the
// receiver takes it. the output register and finish register form a two-deep
// buffer; s_axis_tready drops only when both hold a result and the receiver
// stalls. the user writes max_sector and start_position through the cfg port
// only while no batch result is pending; the block does not enforce this. reset
// sets max_sector to 199, start_position to 0, clears batch statistics, empties the output.
`default_nettype none

module disk_seek_distance_unit #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned TOTAL_WIDTH    = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire dsd_pkg::cfg_idx_e                       cfg_idx_i,
  input  wire logic [POSITION_WIDTH-1:0]               cfg_wdata_i,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // request_position
  input  wire logic [((POSITION_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  wire logic                                    s_axis_tlast,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // fcfs_total, scan_total, cscan_total
  output logic [((3*TOTAL_WIDTH+7)/8)*8-1:0]           m_axis_tdata
);

  import dsd_pkg::*;

  localparam int unsigned P     = POSITION_WIDTH;
  localparam int unsigned TW    = TOTAL_WIDTH;
  localparam int unsigned OUT_W = ((3*TOTAL_WIDTH+7)/8)*8;
  localparam int unsigned XW    = (P + 3 > TW + 2) ? P + 3 : TW + 2;

  typedef logic [P-1:0]          pos_t;
  typedef logic [TW-1:0]         tot_t;
  typedef logic signed [XW-1:0]  wide_t;

  typedef struct packed {
    tot_t fcfs;
    pos_t lo;
    pos_t hi;
    pos_t nb;
    logic bs;
    pos_t na;
    logic as_;
    pos_t cb;
  } fin_t;

  function automatic wide_t ext(input pos_t x);
    return wide_t'(x);
  endfunction

  function automatic tot_t sat(input wide_t v);
    if (v < 0 || v > wide_t'({TW{1'b1}})) begin
      return {TW{1'b1}};
    end
    return v[TW-1:0];
  endfunction

  // configuration
  pos_t max_sector_q, start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sector_q <= P'(MaxSectorReset);
      start_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxSector:     max_sector_q <= cfg_wdata_i;
        CfgStartPosition: start_q      <= cfg_wdata_i;
      endcase
    end
  end

  // batch statistics
  logic first_q, bs_q, as_q;
  pos_t prev_q, lo_q, hi_q, nb_q, na_q, cb_q;
  tot_t fcfs_q;

  pos_t r, prev, diff;
  logic le_start;
  fin_t nxt;

  always_comb begin
    r        = s_axis_tdata[P-1:0];
    prev     = first_q ? start_q : prev_q;
    diff     = (r >= prev) ? r - prev : prev - r;
    le_start = (r <= start_q);
    nxt.fcfs = sat(wide_t'(fcfs_q) + ext(diff));
    if (first_q) begin
      nxt.lo = r;
      nxt.hi = r;
      nxt.cb = r;
    end else begin
      nxt.lo = (r < lo_q) ? r : lo_q;
      nxt.hi = (r > hi_q) ? r : hi_q;
      nxt.cb = (r > cb_q && r < start_q) ? r : cb_q;
    end
    nxt.nb  = (le_start && (!bs_q || r > nb_q)) ? r : nb_q;
    nxt.bs  = bs_q | le_start;
    nxt.na  = (!le_start && (!as_q || r < na_q)) ? r : na_q;
    nxt.as_ = as_q | !le_start;
  end

  // finish and output stages
  logic fin_valid_q, out_valid_q, out_load, in_acc;
  fin_t fin_q;
  tot_t fcfs_o_q, scan_o_q, cscan_o_q;

  assign out_load      = fin_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !fin_valid_q || !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      prev_q  <= '0;
      fcfs_q  <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      nb_q    <= '0;
      bs_q    <= 1'b0;
      na_q    <= '0;
      as_q    <= 1'b0;
      cb_q    <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        first_q <= 1'b1;
        prev_q  <= '0;
        fcfs_q  <= '0;
        lo_q    <= '0;
        hi_q    <= '0;
        nb_q    <= '0;
        bs_q    <= 1'b0;
        na_q    <= '0;
        as_q    <= 1'b0;
        cb_q    <= '0;
      end else begin
        first_q <= 1'b0;
        prev_q  <= r;
        fcfs_q  <= nxt.fcfs;
        lo_q    <= nxt.lo;
        hi_q    <= nxt.hi;
        nb_q    <= nxt.nb;
        bs_q    <= nxt.bs;
        na_q    <= nxt.na;
        as_q    <= nxt.as_;
        cb_q    <= nxt.cb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && s_axis_tlast) begin
        fin_valid_q <= 1'b1;
      end else if (out_load) begin
        fin_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      fin_q <= nxt;
    end
  end

  // closing totals
  wide_t s_w, m_w, l_w, h_w, b_w, a_w, d_below, d_above, scan_v, cscan_v, add_w;
  logic  down_first;

  always_comb begin
    s_w     = ext(start_q);
    m_w     = ext(max_sector_q);
    l_w     = ext(fin_q.lo);
    h_w     = ext(fin_q.hi);
    b_w     = ext(fin_q.nb);
    a_w     = ext(fin_q.na);
    d_below = s_w - b_w;
    d_above = a_w - s_w;
    // unsigned wrap compare: a negative difference counts as huge
    if ((d_below < 0) == (d_above < 0)) begin
      down_first = d_below < d_above;
    end else begin
      down_first = d_above < 0;
    end
    if (!fin_q.bs) begin
      scan_v = (h_w >= s_w) ? h_w - s_w : s_w - h_w;
    end else if (!fin_q.as_) begin
      scan_v = (s_w >= l_w) ? s_w - l_w : l_w - s_w;
    end else if (down_first) begin
      scan_v = (s_w - l_w) + h_w;
    end else begin
      scan_v = (h_w - s_w) + ((m_w >= b_w) ? m_w - b_w : b_w - m_w) + (b_w - l_w);
    end
    if (s_w < h_w && s_w > l_w) begin
      add_w = ext(fin_q.cb);
    end else if (s_w <= l_w) begin
      add_w = '0;
    end else begin
      add_w = h_w;
    end
    if (s_w <= l_w) begin
      cscan_v = h_w - s_w;
    end else if (m_w + add_w > s_w) begin
      cscan_v = m_w + add_w - s_w;
    end else begin
      cscan_v = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fcfs_o_q  <= fin_q.fcfs;
      scan_o_q  <= sat(scan_v);
      cscan_o_q <= sat(cscan_v);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({cscan_o_q, scan_o_q, fcfs_o_q});

  `include "disk_seek_distance_unit_defines.svh"

  `DSD_ASSERT_NEXT(a_last_fills_fin, in_acc && s_axis_tlast, fin_valid_q, "last item lost")
  `DSD_ASSERT_NEXT(a_last_clears_batch, in_acc && s_axis_tlast, first_q, "batch not cleared")
  `DSD_ASSERT_NEXT(a_fin_to_out, out_load, out_valid_q, "finish stage not moved to output")
  `DSD_ASSERT_SAME(a_seen_needs_item, bs_q || as_q, !first_q, "side seen with empty batch")
  `DSD_ASSERT_SAME(a_lo_le_hi, !first_q, lo_q <= hi_q, "lowest above highest")

endmodule

`default_nettype wire
